>>> design/sirs_pkg.sv
`default_nettype none

package sirs_pkg;

  localparam int VALUE_W       = 32;
  localparam int SYM_W         = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int BASE_W        = 5;
  localparam int MAX_BASE_DEF  = 16;
  localparam int MAX_DIGITS    = 32;
  localparam int DIG_IDX_W     = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  localparam logic [BASE_W-1:0]     BASE_SIZE_RST    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SIZE    = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_idx_e;

  function automatic logic [SYM_W-1:0] digit_sym(logic [CFG_DATA_W-1:0] lo,
                                                 logic [CFG_DATA_W-1:0] hi,
                                                 logic [3:0] d);
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{d, 3'b000} +: SYM_W];
  endfunction

endpackage

`default_nettype wire

>>> design/signed_int_to_radix_symbols.sv
// Writes a signed 32-bit value as text in a configurable radix (2 to MAX_BASE) using a
// configurable alphabet of byte-wide symbols, one symbol per output beat, most significant
// digit first, with a leading '-' for negative values and last set on the final beat. An
// alphabet that is too short, too long, holds a repeated symbol, '+', '-' or a zero code
// gives a single beat with status 1 instead. Digits come from repeated division by the
// radix in a shared restoring divider that retires 8 quotient bits per cycle. All digits
// are found before the first beat, and a new value is taken only after the last beat is
// loaded. Configuration writes are taken every cycle and must only be issued while the
// block is idle.
`default_nettype none

module signed_int_to_radix_symbols #(
  parameter int MAX_BASE = sirs_pkg::MAX_BASE_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [sirs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [sirs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [sirs_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [sirs_pkg::SYM_W-1:0]        symbol_o,
  output logic                              last_o,
  output logic                              status_o
);

  localparam int DIG_W = $clog2(MAX_BASE);
  localparam int CMP_W = sirs_pkg::BASE_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_ERR
  } state_e;

  state_e state_q;

  logic [sirs_pkg::BASE_W-1:0]     base_size_q;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_low_q;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_high_q;

  logic [sirs_pkg::VALUE_W-1:0]   work_q, work_d;
  logic [DIG_W-1:0]               rem_q, rem_d;
  logic [sirs_pkg::STEP_W-1:0]    step_q;
  logic [sirs_pkg::DIG_CNT_W-1:0] ndig_q;
  logic                           sign_q;
  logic [DIG_W-1:0]               dig_q [sirs_pkg::MAX_DIGITS];

  logic                           out_valid_q;
  logic [sirs_pkg::SYM_W-1:0]     symbol_q;
  logic                           last_q;
  logic                           status_q;

  logic                           alpha_ok;
  logic                           in_fire;
  logic                           out_free;
  logic                           out_load;
  logic                           div_done;
  logic [sirs_pkg::VALUE_W-1:0]   mag;
  logic [sirs_pkg::SYM_W-1:0]     rd_sym;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = out_free && (state_q == S_EMIT || state_q == S_ERR);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

  assign mag = value_i[sirs_pkg::VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  // alphabet check
  always_comb begin
    logic [sirs_pkg::SYM_W-1:0] si;
    si       = '0;
    alpha_ok = (base_size_q >= sirs_pkg::BASE_W'(2)) &&
               (base_size_q <= sirs_pkg::BASE_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (sirs_pkg::BASE_W'(i) < base_size_q) begin
        si = sirs_pkg::digit_sym(symbols_low_q, symbols_high_q, 4'(i));
        if (si == sirs_pkg::SYM_PLUS || si == sirs_pkg::SYM_MINUS ||
            si == sirs_pkg::SYM_NUL) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (sirs_pkg::BASE_W'(j) < base_size_q &&
              sirs_pkg::digit_sym(symbols_low_q, symbols_high_q, 4'(j)) == si) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // one byte of restoring division by the radix
  always_comb begin
    logic [CMP_W-1:0]               trial;
    logic [sirs_pkg::BITS_PER_STEP-1:0] qbits;
    logic [DIG_W-1:0]               r;
    r     = rem_q;
    qbits = '0;
    trial = '0;
    for (int j = sirs_pkg::BITS_PER_STEP - 1; j >= 0; j--) begin
      trial = CMP_W'({r, work_q[sirs_pkg::VALUE_W - sirs_pkg::BITS_PER_STEP + j]});
      if (trial >= CMP_W'(base_size_q)) begin
        r        = DIG_W'(trial - CMP_W'(base_size_q));
        qbits[j] = 1'b1;
      end else begin
        r = DIG_W'(trial);
      end
    end
    rem_d  = r;
    work_d = {work_q[sirs_pkg::VALUE_W-sirs_pkg::BITS_PER_STEP-1:0], qbits};
  end

  assign div_done = (step_q == sirs_pkg::STEP_W'(sirs_pkg::DIV_STEPS - 1));
  assign rd_sym   = sirs_pkg::digit_sym(symbols_low_q, symbols_high_q, 4'(dig_q[0]));

  // digit stack: newest digit at the head, popped most significant first
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_done) begin
      dig_q[0] <= rem_d;
      for (int k = 1; k < sirs_pkg::MAX_DIGITS; k++) begin
        dig_q[k] <= dig_q[k-1];
      end
    end else if (state_q == S_EMIT && out_free && !sign_q) begin
      for (int k = 0; k < sirs_pkg::MAX_DIGITS - 1; k++) begin
        dig_q[k] <= dig_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      base_size_q    <= sirs_pkg::BASE_SIZE_RST;
      symbols_low_q  <= sirs_pkg::SYMBOLS_LOW_RST;
      symbols_high_q <= sirs_pkg::SYMBOLS_HIGH_RST;
      work_q         <= '0;
      rem_q          <= '0;
      step_q         <= '0;
      ndig_q         <= '0;
      sign_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      symbol_q       <= '0;
      last_q         <= 1'b0;
      status_q       <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sirs_pkg::CFG_BASE_SIZE:    base_size_q    <= cfg_data_i[sirs_pkg::BASE_W-1:0];
          sirs_pkg::CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data_i;
          sirs_pkg::CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            work_q <= mag;
            sign_q <= value_i[sirs_pkg::VALUE_W-1];
            rem_q  <= '0;
            step_q <= '0;
            ndig_q <= '0;
            state_q <= alpha_ok ? S_DIV : S_ERR;
          end
        end
        S_DIV: begin
          if (div_done) begin
            work_q <= work_d;
            rem_q  <= '0;
            step_q <= '0;
            ndig_q <= ndig_q + 1'b1;
            if (work_d == '0) begin
              state_q <= S_EMIT;
            end
          end else begin
            work_q <= work_d;
            rem_q  <= rem_d;
            step_q <= step_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            status_q    <= 1'b0;
            if (sign_q) begin
              symbol_q <= sirs_pkg::SYM_MINUS;
              last_q   <= 1'b0;
              sign_q   <= 1'b0;
            end else begin
              symbol_q <= rd_sym;
              last_q   <= (ndig_q == sirs_pkg::DIG_CNT_W'(1));
              ndig_q   <= ndig_q - 1'b1;
              if (ndig_q == sirs_pkg::DIG_CNT_W'(1)) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            symbol_q    <= sirs_pkg::SYM_NUL;
            last_q      <= 1'b1;
            status_q    <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= sirs_pkg::DIG_CNT_W'(sirs_pkg::MAX_DIGITS))
    else $error("digit count overflow");

  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> ndig_q != '0)
    else $error("emitting with no digits stored");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o)
    else $error("invalid-alphabet beat not marked last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted value left no work");

  a_div_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < DIG_W'(MAX_BASE - 1) || rem_q == DIG_W'(MAX_BASE - 1))
    else $error("remainder out of range");
`endif

endmodule

`default_nettype wire
